// ----- hdl/hgrp_pkg.sv -----
// Shared types, constants and character helpers for the GET request line parser.
// No dependencies; every other file in hdl imports this package.
`timescale 1ns / 1ps

package hgrp_pkg;

	localparam int CNT_W            = 12;
	localparam int MAX_FIELD_LENGTH = 4095;
	localparam int MAX_ITEMS        = 3;
	localparam int ITEM_CNT_W       = $clog2(MAX_ITEMS + 1);
	localparam int QUEUE_DEPTH      = 4;
	localparam int QUEUE_IDX_W      = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W      = $clog2(QUEUE_DEPTH + 1);
	localparam int CFG_INDEX_W      = 1;
	localparam int CFG_DATA_W       = 12;

	localparam logic [CNT_W-1:0] MAX_COUNT   = CNT_W'(MAX_FIELD_LENGTH);
	localparam logic [CNT_W-1:0] RESET_LIMIT = CNT_W'(1022);

	localparam logic [CFG_INDEX_W-1:0] CFG_MAX_NAME  = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] CFG_MAX_QUERY = 1'b1;

	localparam logic [1:0] KIND_NAME   = 2'd0;
	localparam logic [1:0] KIND_QUERY  = 2'd1;
	localparam logic [1:0] KIND_STATUS = 2'd2;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_CONN     = 3'd1;
	localparam logic [2:0] ST_BAD_REQ  = 3'd2;
	localparam logic [2:0] ST_METHOD   = 3'd3;
	localparam logic [2:0] ST_FILENAME = 3'd4;
	localparam logic [2:0] ST_QUERY    = 3'd5;

	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_LF      = 8'h0A;
	localparam logic [7:0] CH_CR      = 8'h0D;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_SLASH   = 8'h2F;
	localparam logic [7:0] CH_QMARK   = 8'h3F;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
		logic [2:0] status;
		logic       last;
	} item_t;

	typedef struct packed {
		logic [ITEM_CNT_W-1:0] count;
		item_t [MAX_ITEMS-1:0] items;
	} item_group_t;

	function automatic logic is_hex(input logic [7:0] c);
		return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
	endfunction

	function automatic logic [3:0] hex_val(input logic [7:0] c);
		logic [7:0] v;
		v = 8'd0;
		if (c >= "0" && c <= "9") begin
			v = c - 8'h30;
		end else if (c >= "a" && c <= "f") begin
			v = c - 8'h57;
		end else if (c >= "A" && c <= "F") begin
			v = c - 8'h37;
		end
		return v[3:0];
	endfunction

	function automatic logic [7:0] to_upper(input logic [7:0] c);
		return (c >= "a" && c <= "z") ? c - 8'h20 : c;
	endfunction

endpackage

// ----- hdl/hgrp_parser.sv -----
// Request line parser state and per-beat result generation (up to three items).
// Depends on hgrp_pkg.
`timescale 1ns / 1ps

module hgrp_parser
	import hgrp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  logic             action,
	input  logic [7:0]       data_byte,
	input  logic [CNT_W-1:0] max_name_length,
	input  logic [CNT_W-1:0] max_query_length,
	output item_group_t      result
);

	typedef enum logic [2:0] {
		PH_METHOD, PH_GAP, PH_PATH, PH_QUERY, PH_REST, PH_HEADERS
	} phase_t;

	typedef enum logic [1:0] {
		ESC_NONE, ESC_PCT, ESC_HEX
	} esc_t;

	typedef struct packed {
		phase_t           phase;
		logic [2:0]       method_count;
		logic             method_bad;
		esc_t             esc;
		logic [7:0]       esc_char;
		logic             slash_checked;
		logic             slash_missing;
		logic [CNT_W-1:0] name_count;
		logic [CNT_W-1:0] query_count;
		logic             protocol_found;
		logic [23:0]      recent;
	} state_t;

	localparam state_t CLEAR_STATE = '{
		phase: PH_METHOD, method_count: 3'd0, method_bad: 1'b0, esc: ESC_NONE,
		esc_char: 8'd0, slash_checked: 1'b0, slash_missing: 1'b0,
		name_count: '0, query_count: '0, protocol_found: 1'b0, recent: 24'd0
	};

	state_t                st_q;
	state_t                nxt;
	logic [7:0]            cand   [MAX_ITEMS];
	logic [ITEM_CNT_W-1:0] n_cand;
	logic [ITEM_CNT_W-1:0] n_out;
	logic [ITEM_CNT_W-1:0] n_name;
	logic                  do_decode;
	logic                  do_end_path;
	logic                  query_push;
	logic                  is_eol;
	logic                  is_ws;
	logic                  terminator;
	logic [CNT_W:0]        name_sum;
	logic [2:0]            status;
	logic [7:0]            method_ref;

	assign is_eol = (data_byte == CH_LF) || (data_byte == CH_CR);
	assign is_ws  = (data_byte == CH_SPACE) || (data_byte == CH_TAB);

	always_comb begin
		unique case (st_q.method_count)
			3'd0:    method_ref = "G";
			3'd1:    method_ref = "E";
			3'd2:    method_ref = "T";
			default: method_ref = 8'd0;
		endcase
	end

	always_comb begin
		nxt         = st_q;
		do_decode   = 1'b0;
		do_end_path = 1'b0;
		query_push  = 1'b0;
		n_cand      = '0;
		n_out       = '0;
		n_name      = '0;
		status      = ST_OK;
		terminator  = 1'b0;
		name_sum    = '0;
		result      = '0;
		for (int i = 0; i < MAX_ITEMS; i++) begin
			cand[i] = 8'd0;
		end

		// Phase handling for one request byte.
		unique case (st_q.phase)
			PH_METHOD: begin
				if (is_eol) begin
					nxt.phase = PH_HEADERS;
				end else if (is_ws) begin
					if (st_q.method_count != 3'd3) nxt.method_bad = 1'b1;
					nxt.phase = PH_GAP;
				end else begin
					if (st_q.method_count >= 3'd3 || to_upper(data_byte) != method_ref)
						nxt.method_bad = 1'b1;
					if (st_q.method_count < 3'd4) nxt.method_count = st_q.method_count + 3'd1;
				end
			end
			PH_GAP: begin
				if (is_eol) begin
					nxt.phase = PH_HEADERS;
				end else if (!is_ws) begin
					if (data_byte == CH_QMARK) begin
						do_end_path = 1'b1;
						nxt.phase   = PH_QUERY;
					end else begin
						do_decode = 1'b1;
						nxt.phase = PH_PATH;
					end
				end
			end
			PH_PATH: begin
				if (is_eol) begin
					do_end_path = 1'b1;
					nxt.phase   = PH_HEADERS;
				end else if (is_ws) begin
					do_end_path        = 1'b1;
					nxt.protocol_found = 1'b1;
					nxt.phase          = PH_REST;
				end else if (data_byte == CH_QMARK) begin
					do_end_path = 1'b1;
					nxt.phase   = PH_QUERY;
				end else begin
					do_decode = 1'b1;
				end
			end
			PH_QUERY: begin
				if (is_eol) begin
					nxt.phase = PH_HEADERS;
				end else if (is_ws) begin
					nxt.protocol_found = 1'b1;
					nxt.phase          = PH_REST;
				end else begin
					query_push = 1'b1;
					if (st_q.query_count < MAX_COUNT) nxt.query_count = st_q.query_count + 1'b1;
				end
			end
			PH_REST: begin
				if (is_eol) nxt.phase = PH_HEADERS;
			end
			default: begin
			end
		endcase

		// Percent decoding: collect the file name bytes this beat produces, in order.
		if (do_decode || do_end_path) begin
			if (st_q.esc == ESC_PCT || st_q.esc == ESC_HEX) begin
				if (do_end_path || !is_hex(data_byte)) begin
					cand[n_cand] = CH_PERCENT;
					n_cand       = n_cand + 1'b1;
					if (st_q.esc == ESC_HEX) begin
						cand[n_cand] = st_q.esc_char;
						n_cand       = n_cand + 1'b1;
					end
					nxt.esc = ESC_NONE;
				end
			end
		end
		if (do_decode) begin
			if (st_q.esc == ESC_PCT && is_hex(data_byte)) begin
				nxt.esc      = ESC_HEX;
				nxt.esc_char = data_byte;
			end else if (st_q.esc == ESC_HEX && is_hex(data_byte)) begin
				cand[n_cand] = {hex_val(st_q.esc_char), hex_val(data_byte)};
				n_cand       = n_cand + 1'b1;
				nxt.esc      = ESC_NONE;
			end else if (data_byte == CH_PERCENT) begin
				nxt.esc = ESC_PCT;
			end else begin
				cand[n_cand] = data_byte;
				n_cand       = n_cand + 1'b1;
			end
		end

		// The first decoded byte is checked against the slash and not emitted.
		for (int i = 0; i < MAX_ITEMS; i++) begin
			if (ITEM_CNT_W'(i) < n_cand) begin
				if (!nxt.slash_checked) begin
					nxt.slash_checked = 1'b1;
					nxt.slash_missing = (cand[i] != CH_SLASH);
				end else begin
					result.items[n_out].kind = KIND_NAME;
					result.items[n_out].data = cand[i];
					n_out  = n_out + 1'b1;
					n_name = n_name + 1'b1;
				end
			end
		end
		if (do_end_path && !nxt.slash_checked) begin
			nxt.slash_checked = 1'b1;
			nxt.slash_missing = 1'b1;
		end
		name_sum = {1'b0, st_q.name_count} + (CNT_W + 1)'(n_name);
		nxt.name_count = (name_sum > {1'b0, MAX_COUNT}) ? MAX_COUNT : name_sum[CNT_W-1:0];

		if (query_push) begin
			result.items[n_out].kind = KIND_QUERY;
			result.items[n_out].data = data_byte;
			n_out = n_out + 1'b1;
		end

		// End of request: blank line after the header block.
		terminator = (data_byte == CH_LF) &&
			((st_q.recent[7:0] == CH_LF) || (st_q.recent == {CH_CR, CH_LF, CH_CR}));
		if (!nxt.protocol_found) begin
			status = ST_BAD_REQ;
		end else if (nxt.method_bad) begin
			status = ST_METHOD;
		end else if (nxt.slash_missing) begin
			status = ST_FILENAME;
		end else if (nxt.name_count > max_name_length) begin
			status = ST_FILENAME;
		end else if (nxt.query_count > max_query_length) begin
			status = ST_QUERY;
		end else begin
			status = ST_OK;
		end

		if (action) begin
			result.items[0]      = '0;
			result.items[0].kind   = KIND_STATUS;
			result.items[0].status = ST_CONN;
			result.items[0].last   = 1'b1;
			n_out = ITEM_CNT_W'(1);
			nxt   = CLEAR_STATE;
		end else if (terminator) begin
			result.items[n_out].kind   = KIND_STATUS;
			result.items[n_out].status = status;
			result.items[n_out].last   = 1'b1;
			n_out = n_out + 1'b1;
			nxt   = CLEAR_STATE;
		end else begin
			nxt.recent = {st_q.recent[15:0], data_byte};
		end
		result.count = n_out;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= CLEAR_STATE;
		end else if (fire) begin
			st_q <= nxt;
		end
	end

endmodule

// ----- hdl/hgrp_out_queue.sv -----
// Small result queue: takes up to three items per beat, hands out one per beat.
// Depends on hgrp_pkg.
`timescale 1ns / 1ps

module hgrp_out_queue
	import hgrp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  item_group_t group,
	output logic        space,
	output logic        out_valid,
	input  logic        out_ready,
	output item_t       out_item
);

	item_t                  ent_q [QUEUE_DEPTH];
	logic [QUEUE_IDX_W-1:0] head_q;
	logic [QUEUE_CNT_W-1:0] count_q;
	logic [QUEUE_IDX_W-1:0] tail;
	logic                   pop;
	logic [ITEM_CNT_W-1:0]  push_n;

	assign space     = (count_q <= QUEUE_CNT_W'(QUEUE_DEPTH - MAX_ITEMS));
	assign out_valid = (count_q != '0);
	assign out_item  = ent_q[head_q];
	assign pop       = out_valid && out_ready;
	assign push_n    = push ? group.count : '0;
	assign tail      = head_q + count_q[QUEUE_IDX_W-1:0];

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_ITEMS; i++) begin
			if (ITEM_CNT_W'(i) < push_n) begin
				ent_q[tail + QUEUE_IDX_W'(i)] <= group.items[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else begin
			if (pop) head_q <= head_q + 1'b1;
			count_q <= count_q + QUEUE_CNT_W'(push_n) - QUEUE_CNT_W'(pop);
		end
	end

endmodule

// ----- hdl/http_get_request_line_parser_core.sv -----
// Top level of the HTTP GET request line parser: configuration registers,
// parser and result queue. Depends on hgrp_pkg, hgrp_parser and hgrp_out_queue.
`timescale 1ns / 1ps

// The block takes an HTTP request as a stream of beats, one byte per beat
// (tuser low), or a connection-closed event (tuser high). It checks that the
// method is GET in any letter case, percent-decodes the path, checks that it
// starts with a slash, and emits each decoded file name byte (tuser 0) and each
// raw query byte after the first '?' (tuser 1) as it arrives. After a blank line
// (CR LF CR LF or LF LF) it emits one status beat (tuser 2, tlast high) and starts
// over on the next request. Status codes are 0 ok, 1 connection closed, 2 bad
// request, 3 method, 4 file name, 5 query; when the status is not ok, the bytes
// already emitted for that request are to be dropped. The user must write the
// limits on name and query length through the cfg port only while the block is
// idle; the block does not enforce this. Rate: one input beat per clock while
// the queue has room; each beat is handled in the clock it is taken, and its
// results (at most three beats, when an unfinished escape is flushed) go into a
// four-entry result queue; the input is ready whenever that queue holds at most
// one beat, so a steady stream of one-result beats flows at one beat per clock,
// and a beat with several results costs the extra clocks needed to drain them.

module http_get_request_line_parser_core
	import hgrp_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [7:0]             s_axis_tdata,  // [7:0] data_byte
	input  logic                   s_axis_tuser,  // [0] action
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [15:0]            m_axis_tdata,  // [7:0] out_byte, [10:8] status_code
	output logic [1:0]             m_axis_tuser,  // [1:0] item_kind
	output logic                   m_axis_tlast,  // last_of_request
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	logic [CNT_W-1:0] max_name_q;
	logic [CNT_W-1:0] max_query_q;
	logic             in_fire;
	item_group_t      group;
	item_t            head;

	// Length limits; reset to 1022 bytes each.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_name_q  <= RESET_LIMIT;
			max_query_q <= RESET_LIMIT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MAX_NAME:  max_name_q  <= cfg_data;
				CFG_MAX_QUERY: max_query_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign in_fire = s_axis_tvalid && s_axis_tready;

	hgrp_parser u_parser (
		.clk              (clk),
		.arst_n           (arst_n),
		.fire             (in_fire),
		.action           (s_axis_tuser),
		.data_byte        (s_axis_tdata),
		.max_name_length  (max_name_q),
		.max_query_length (max_query_q),
		.result           (group)
	);

	// The queue is the result register: its head entry drives the output beat.
	hgrp_out_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_fire),
		.group     (group),
		.space     (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_item  (head)
	);

	assign m_axis_tdata = {5'd0, head.status, head.data};
	assign m_axis_tuser = head.kind;
	assign m_axis_tlast = head.last;

endmodule

// ----- sim/hgrp_parse_check.sv -----
// Result checker for the GET request line parser: watches the input, output and
// configuration ports, predicts every output beat and compares. Uses hgrp_pkg.
`timescale 1ns / 1ps

module hgrp_parse_check
	import hgrp_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	input  logic                   s_axis_tready,
	input  logic [7:0]             s_axis_tdata,  // [7:0] data_byte
	input  logic                   s_axis_tuser,  // [0] action
	input  logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	input  logic [15:0]            m_axis_tdata,  // [7:0] out_byte, [10:8] status_code
	input  logic [1:0]             m_axis_tuser,  // [1:0] item_kind
	input  logic                   m_axis_tlast,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output int                     fail_count,
	output int                     pending
);

	typedef enum logic [2:0] {
		LN_METHOD, LN_GAP, LN_PATH, LN_QUERY, LN_PROTO, LN_HEADERS
	} line_phase_t;

	typedef enum logic [1:0] {ESC_NONE, ESC_PCT, ESC_HEX} esc_stage_t;

	logic [CNT_W-1:0] name_limit;
	logic [CNT_W-1:0] query_limit;

	line_phase_t      phase;
	logic [2:0]       meth_len;
	logic             meth_bad;
	esc_stage_t       esc_stage;
	logic [7:0]       esc_hi;
	logic             slash_seen;
	logic             slash_bad;
	logic [CNT_W-1:0] name_len;
	logic [CNT_W-1:0] query_len;
	logic             proto_seen;
	logic [23:0]      tail;

	item_t predicted_beats[$];
	int    errors;

	function automatic logic hex_digit_ok(input logic [7:0] c);
		return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
	endfunction

	function automatic logic [3:0] hex_nibble(input logic [7:0] c);
		logic [7:0] v;
		if (c <= "9") begin
			v = c - "0";
		end else if (c <= "F") begin
			v = c - "A" + 8'd10;
		end else begin
			v = c - "a" + 8'd10;
		end
		return v[3:0];
	endfunction

	task automatic add_beat(input logic [1:0] kind, input logic [7:0] b,
			input logic [2:0] st, input logic last);
		item_t it;
		it.kind   = kind;
		it.data   = b;
		it.status = st;
		it.last   = last;
		predicted_beats.push_back(it);
	endtask

	task automatic new_request();
		phase      = LN_METHOD;
		meth_len   = '0;
		meth_bad   = 1'b0;
		esc_stage  = ESC_NONE;
		esc_hi     = '0;
		slash_seen = 1'b0;
		slash_bad  = 1'b0;
		name_len   = '0;
		query_len  = '0;
		proto_seen = 1'b0;
		tail       = '0;
	endtask

	// The first decoded path byte is only checked for a slash, never emitted.
	task automatic emit_name(input logic [7:0] b);
		if (!slash_seen) begin
			slash_seen = 1'b1;
			slash_bad  = (b != CH_SLASH);
		end else begin
			add_beat(KIND_NAME, b, ST_OK, 1'b0);
			if (name_len < MAX_COUNT) name_len++;
		end
	endtask

	task automatic flush_escape();
		if (esc_stage != ESC_NONE) emit_name(CH_PERCENT);
		if (esc_stage == ESC_HEX) emit_name(esc_hi);
		esc_stage = ESC_NONE;
	endtask

	task automatic close_path();
		flush_escape();
		if (!slash_seen) begin
			slash_seen = 1'b1;
			slash_bad  = 1'b1;
		end
	endtask

	task automatic decode_char(input logic [7:0] c);
		if (esc_stage == ESC_PCT) begin
			if (hex_digit_ok(c)) begin
				esc_hi    = c;
				esc_stage = ESC_HEX;
				return;
			end
			flush_escape();
		end else if (esc_stage == ESC_HEX) begin
			if (hex_digit_ok(c)) begin
				emit_name({hex_nibble(esc_hi), hex_nibble(c)});
				esc_stage = ESC_NONE;
				return;
			end
			flush_escape();
		end
		if (c == CH_PERCENT) begin
			esc_stage = ESC_PCT;
		end else begin
			emit_name(c);
		end
	endtask

	task automatic method_char(input logic [7:0] c);
		logic [7:0] up;
		logic [7:0] want;
		up = (c >= "a" && c <= "z") ? c - 8'h20 : c;
		case (meth_len)
			3'd0: want = "G";
			3'd1: want = "E";
			default: want = "T";
		endcase
		if (meth_len >= 3'd3 || up != want) meth_bad = 1'b1;
		if (meth_len < 3'd4) meth_len++;
	endtask

	task automatic parse_request_beat(input logic act, input logic [7:0] c);
		logic       eol;
		logic       ws;
		logic [2:0] st;
		if (act) begin
			add_beat(KIND_STATUS, 8'h00, ST_CONN, 1'b1);
			new_request();
			return;
		end
		eol = (c == CH_LF) || (c == CH_CR);
		ws  = (c == CH_SPACE) || (c == CH_TAB);
		case (phase)
			LN_METHOD: begin
				if (eol) begin
					phase = LN_HEADERS;
				end else if (ws) begin
					if (meth_len != 3'd3) meth_bad = 1'b1;
					phase = LN_GAP;
				end else begin
					method_char(c);
				end
			end
			LN_GAP: begin
				if (eol) begin
					phase = LN_HEADERS;
				end else if (!ws) begin
					if (c == CH_QMARK) begin
						close_path();
						phase = LN_QUERY;
					end else begin
						phase = LN_PATH;
						decode_char(c);
					end
				end
			end
			LN_PATH: begin
				if (eol) begin
					close_path();
					phase = LN_HEADERS;
				end else if (ws) begin
					close_path();
					proto_seen = 1'b1;
					phase = LN_PROTO;
				end else if (c == CH_QMARK) begin
					close_path();
					phase = LN_QUERY;
				end else begin
					decode_char(c);
				end
			end
			LN_QUERY: begin
				if (eol) begin
					phase = LN_HEADERS;
				end else if (ws) begin
					proto_seen = 1'b1;
					phase = LN_PROTO;
				end else begin
					add_beat(KIND_QUERY, c, ST_OK, 1'b0);
					if (query_len < MAX_COUNT) query_len++;
				end
			end
			LN_PROTO: begin
				if (eol) phase = LN_HEADERS;
			end
			default: ;
		endcase
		// A blank line ends the request: LF LF, or CR LF CR LF.
		if (c == CH_LF && (tail[7:0] == CH_LF || tail == {CH_CR, CH_LF, CH_CR})) begin
			if (!proto_seen) begin
				st = ST_BAD_REQ;
			end else if (meth_bad) begin
				st = ST_METHOD;
			end else if (slash_bad || name_len > name_limit) begin
				st = ST_FILENAME;
			end else if (query_len > query_limit) begin
				st = ST_QUERY;
			end else begin
				st = ST_OK;
			end
			add_beat(KIND_STATUS, 8'h00, st, 1'b1);
			new_request();
		end else begin
			tail = {tail[15:0], c};
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		item_t got;
		item_t want;
		if (!arst_n) begin
			name_limit  = RESET_LIMIT;
			query_limit = RESET_LIMIT;
			new_request();
			predicted_beats.delete();
			errors = 0;
			fail_count <= 0;
			pending    <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_MAX_NAME) begin
					name_limit = cfg_data;
				end else if (cfg_index == CFG_MAX_QUERY) begin
					query_limit = cfg_data;
				end
			end
			if (s_axis_tvalid && s_axis_tready) parse_request_beat(s_axis_tuser, s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready) begin
				got.kind   = m_axis_tuser;
				got.data   = m_axis_tdata[7:0];
				got.status = m_axis_tdata[10:8];
				got.last   = m_axis_tlast;
				if (predicted_beats.size() == 0) begin
					$display("%0t: unexpected beat kind=%0d byte=%02h status=%0d last=%0d",
						$time, got.kind, got.data, got.status, got.last);
					errors++;
				end else begin
					want = predicted_beats.pop_front();
					if (got.kind != want.kind || got.data != want.data ||
							got.status != want.status || got.last != want.last) begin
						$display("%0t: mismatch expected kind=%0d byte=%02h status=%0d last=%0d",
							$time, want.kind, want.data, want.status, want.last);
						$display("%0t:          actual kind=%0d byte=%02h status=%0d last=%0d",
							$time, got.kind, got.data, got.status, got.last);
						errors++;
					end
				end
			end
			fail_count <= errors;
			pending    <= predicted_beats.size();
		end
	end

endmodule

// ----- sim/tb_http_get_request_line_parser_core.sv -----
// Testbench top for the GET request line parser: clock, reset, request stimulus
// and verdict. Depends on hgrp_pkg, hgrp_parse_check and the parser core.
`timescale 1ns / 1ps

module tb_http_get_request_line_parser_core;
	import hgrp_pkg::*;

	// The run sends about two hundred and forty beats, and the cycle limit leaves a
	// wide margin even at the heaviest idling.
	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE      = 8;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [7:0]             s_axis_tdata;
	logic                   s_axis_tuser;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [15:0]            m_axis_tdata;
	logic [1:0]             m_axis_tuser;
	logic                   m_axis_tlast;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	int fail_count;
	int pending;
	int tx_idle_pct  = 0;
	int rx_stall_pct = 0;
	int beats_sent   = 0;

	http_get_request_line_parser_core uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	hgrp_parse_check parse_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	always #4 clk = ~clk;

	// The receiver drops tready at random, at the rate the current phase asks for.
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
	end

	// Present one beat, with a random idle gap ahead of it, and hold it until the
	// block takes it. During the gap the data lines carry junk that must be ignored.
	task automatic send_beat(input logic act, input logic [7:0] b);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= 8'($urandom_range(255));
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= act;
		s_axis_tdata  <= b;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		beats_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_beat(1'b0, s[i]);
	endtask

	// Upper-case letters come back in either case, to exercise the case-blind
	// method compare.
	function automatic logic [7:0] random_case(input logic [7:0] b);
		return $urandom_range(1) ? (b | 8'h20) : b;
	endfunction

	// Path content leans on percent escapes and hex digits so that complete,
	// broken and unfinished escapes all occur often.
	function automatic logic [7:0] path_char();
		string hex_chars;
		hex_chars = "0123456789abcdefABCDEF";
		case ($urandom_range(9))
			0, 1:    return CH_PERCENT;
			2, 3, 4: return hex_chars[$urandom_range(21)];
			5:       return 8'($urandom_range(255));
			default: return 8'($urandom_range(122, 97));
		endcase
	endfunction

	function automatic logic [7:0] query_char();
		if ($urandom_range(4) == 0) return 8'($urandom_range(255));
		return 8'($urandom_range(126, 33));
	endfunction

	// One request with random content. Most are well formed so that the path,
	// query and status logic is reached; the rest carry a wrong method, a missing
	// slash or protocol, stray bytes or a dropped connection.
	task automatic send_request();
		int         n;
		logic [7:0] b;
		string      word;
		word = "GET";
		if ($urandom_range(9) == 0) begin
			n = $urandom_range(6, 1);
			repeat (n) send_beat($urandom_range(9) == 0, 8'($urandom_range(255)));
		end
		if ($urandom_range(7) == 0) begin
			n = $urandom_range(4);
			for (int i = 0; i < n; i++) begin
				if (i < 3 && $urandom_range(1)) begin
					b = word[i];
				end else begin
					b = 8'($urandom_range(90, 65));
				end
				send_beat(1'b0, random_case(b));
			end
		end else begin
			for (int i = 0; i < 3; i++) send_beat(1'b0, random_case(word[i]));
		end
		n = $urandom_range(2, 1);
		repeat (n) send_beat(1'b0, $urandom_range(1) ? CH_SPACE : CH_TAB);
		if ($urandom_range(9) != 0) send_beat(1'b0, CH_SLASH);
		n = $urandom_range(5);
		repeat (n) send_beat(1'b0, path_char());
		if ($urandom_range(9) < 6) begin
			send_beat(1'b0, CH_QMARK);
			n = $urandom_range(5);
			repeat (n) send_beat(1'b0, query_char());
		end
		if ($urandom_range(9) != 0) begin
			send_beat(1'b0, $urandom_range(1) ? CH_SPACE : CH_TAB);
			send_text("H/1");
		end
		case ($urandom_range(7))
			0, 1, 2: send_text("\015\n\015\n");
			3, 4:    send_text("\n\n");
			5:       send_text("\015\nA: b\015\n\015\n");
			6:       send_text("\n\015\n\n");
			default: send_beat(1'b1, 8'($urandom_range(255)));
		endcase
	endtask

	task automatic run_phase(input int idle, input int stall, input int beats);
		int target;
		tx_idle_pct  = idle;
		rx_stall_pct = stall;
		target = beats_sent + beats;
		while (beats_sent < target) send_request();
	endtask

	// Stop sending, wait until every predicted beat has come out, then let the
	// block settle so that nothing is still in flight.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Both limits are written on consecutive clocks, only while the block is idle.
	task automatic set_limits(input logic [CFG_DATA_W-1:0] name_max,
			input logic [CFG_DATA_W-1:0] query_max);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_MAX_NAME;
		cfg_data  <= name_max;
		@(posedge clk);
		cfg_index <= CFG_MAX_QUERY;
		cfg_data  <= query_max;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	initial begin
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= 8'h00;
		s_axis_tuser  <= 1'b0;
		cfg_we        <= 1'b0;
		cfg_index     <= CFG_MAX_NAME;
		cfg_data      <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part under the reset limits: a dropped connection first, then a
		// mixed-case GET whose path holds a complete escape and an unfinished one
		// cut off by the query mark, a query with NUL and all-ones bytes, and a
		// request that ends before it has any protocol.
		send_beat(1'b1, 8'hFF);
		send_text("gEt /%41%4?");
		send_beat(1'b0, 8'h00);
		send_beat(1'b0, 8'hFF);
		send_text(" H\n\n");
		send_text("X \015\n\015\n");
		run_phase(0, 0, 45);
		drain();

		// Zero limits: any emitted name or query byte is an error.
		set_limits('0, '0);
		run_phase(48, 0, 45);
		drain();

		// Largest limits.
		set_limits('1, '1);
		run_phase(0, 48, 45);
		drain();

		// Limits right at the random path and query lengths, to hit both sides.
		set_limits(12'd3, 12'd2);
		run_phase(29, 29, 45);
		drain();

		repeat (4 * SETTLE) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("status: fail");
		$finish;
	end

endmodule
